>>> design/ardo_pkg.sv
// ----------------------------------------------------------------------------
// ardo_pkg: arc odometry shared definitions
// State and phase codes, fixed-point constants and the series coefficient
// tables used by the odometry sequencer.
// ----------------------------------------------------------------------------
package ardo_pkg;

    localparam logic [15:0] CPM_RESET   = 16'd1140;
    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam int          SER_TERMS   = 8;
    localparam int          DIV_STEPS   = 48;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ANG,
        ST_SQR,
        ST_X2,
        ST_MT,
        ST_MM,
        ST_MD,
        ST_FIX,
        ST_PMUL,
        ST_PDIV,
        ST_DIV,
        ST_SXM,
        ST_TRIG,
        ST_XL,
        ST_XH,
        ST_XS,
        ST_YL,
        ST_YH,
        ST_YS,
        ST_DONE
    } ardo_state_t;

    typedef enum logic [1:0] {
        PH_SINC,
        PH_SIN,
        PH_COS
    } ardo_phase_t;

    // series denominators (2k)(2k+1) for sin(x)/x, (2k-1)(2k) for cos(x)
    function automatic logic [8:0] ser_den(input logic is_cos, input logic [2:0] k);
        logic [8:0] d;
        if (is_cos) begin
            unique case (k)
                3'd0: d = 9'd2;
                3'd1: d = 9'd12;
                3'd2: d = 9'd30;
                3'd3: d = 9'd56;
                3'd4: d = 9'd90;
                3'd5: d = 9'd132;
                3'd6: d = 9'd182;
                3'd7: d = 9'd240;
                default: d = 9'd2;
            endcase
        end else begin
            unique case (k)
                3'd0: d = 9'd6;
                3'd1: d = 9'd20;
                3'd2: d = 9'd42;
                3'd3: d = 9'd72;
                3'd4: d = 9'd110;
                3'd5: d = 9'd156;
                3'd6: d = 9'd210;
                3'd7: d = 9'd272;
                default: d = 9'd6;
            endcase
        end
        return d;
    endfunction

    // floor(2^32 / den): quotient estimate, low by at most one
    function automatic logic [31:0] ser_recip(input logic is_cos, input logic [2:0] k);
        logic [31:0] m;
        if (is_cos) begin
            unique case (k)
                3'd0: m = 32'd2147483648;
                3'd1: m = 32'd357913941;
                3'd2: m = 32'd143165576;
                3'd3: m = 32'd76695844;
                3'd4: m = 32'd47721858;
                3'd5: m = 32'd32537631;
                3'd6: m = 32'd23598721;
                3'd7: m = 32'd17895697;
                default: m = 32'd2147483648;
            endcase
        end else begin
            unique case (k)
                3'd0: m = 32'd715827882;
                3'd1: m = 32'd214748364;
                3'd2: m = 32'd102261126;
                3'd3: m = 32'd59652323;
                3'd4: m = 32'd39045157;
                3'd5: m = 32'd27531841;
                3'd6: m = 32'd20452225;
                3'd7: m = 32'd15790320;
                default: m = 32'd715827882;
            endcase
        end
        return m;
    endfunction

endpackage

>>> design/arc_dead_reckoning_odometry.sv
// ----------------------------------------------------------------------------
// arc_dead_reckoning_odometry: arc-model dead reckoning
// Integrates encoder and yaw deltas along a circular arc into a saturating
// x/y position, using one shared 32x32 multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | in_valid in_ready encoder_count yaw_angle | in
//  out     | out_valid out_ready pose_x/_y heading     | out
//  cfg     | cfg_valid cfg_ready counts_per_meter      | in
//
//  Each request runs three 8-term series, a 48-step divide by counts_per_meter
//  and the rotate/accumulate steps; the series and rotate steps use the one
//  shared multiplier, while the divide is bit-serial.
//  in_ready is high only in idle; a finished result waits in an output
//  register, so one more request is taken while out_ready is low.
//  Reset clears position, last count/heading and restores counts_per_meter.
// ----------------------------------------------------------------------------
module arc_dead_reckoning_odometry
    import ardo_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] encoder_count,
    input  logic signed [15:0] yaw_angle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pose_x,
    output logic signed [31:0] pose_y,
    output logic signed [15:0] heading,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [15:0] counts_per_meter
);

    ardo_state_t state_reg, state_next;
    ardo_phase_t phase_reg;

    logic [15:0] cpm_reg;
    logic [31:0] last_count_reg;
    logic [15:0] last_heading_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg;

    logic [31:0] lmag_reg;
    logic        lneg_reg;
    logic [16:0] phi2_reg;
    logic [15:0] yaw_reg;
    logic [15:0] r_reg;
    logic [31:0] x_reg;
    logic [31:0] x2_reg;
    logic [30:0] t_reg;
    logic [31:0] v_reg;
    logic [31:0] q_reg;
    logic [2:0]  k_reg;
    logic [30:0] sinc_reg;
    logic [47:0] dq_reg;
    logic [15:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic [30:0] c_reg, s_reg;
    logic        cneg_reg, sneg_reg;
    logic [54:0] pl_reg;
    logic [63:0] prod_reg;

    logic               out_valid_reg;
    logic signed [31:0] out_x_reg, out_y_reg;
    logic [15:0]        out_h_reg;

    logic [31:0] mul_a, mul_b;
    logic        in_take;
    logic        out_load;

    logic [31:0] du;
    logic        dneg;
    logic [15:0] dd;
    logic [15:0] dmag;
    logic [16:0] phi2;

    logic        is_cos;
    logic [8:0]  den;
    logic [31:0] rem_fix;
    logic [32:0] q_fix;
    logic [30:0] t_new;

    logic [15:0] cpm_eff;
    logic [16:0] rem_sh;
    logic        div_ge;

    logic [30:0] sx;
    logic [79:0] qsum;
    logic [48:0] qmag;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] acc,
                                                   input logic [48:0] mag,
                                                   input logic neg);
        logic signed [50:0] av;
        logic signed [50:0] mv;
        logic signed [50:0] s;
        av = {{19{acc[31]}}, acc};
        mv = $signed({2'b00, mag});
        s  = neg ? (av - mv) : (av + mv);
        if (s > $signed(51'h0_7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        else if (s < $signed({{19{1'b1}}, 32'h8000_0000}))
            return 32'sh8000_0000;
        else
            return s[31:0];
    endfunction

    assign in_ready   = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign in_take    = in_valid && in_ready;
    assign out_load   = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign pose_x     = out_x_reg;
    assign pose_y     = out_y_reg;
    assign heading    = out_h_reg;

    // request deltas
    assign du   = encoder_count - last_count_reg;
    assign dd   = yaw_angle - last_heading_reg;
    assign dneg = dd[15];
    assign dmag = dneg ? (16'd0 - dd) : dd;
    assign phi2 = {last_heading_reg, 1'b0} + {1'b0, dd} + {dneg, 16'd0};

    // series term correction
    assign is_cos  = (phase_reg == PH_COS);
    assign den     = ser_den(is_cos, k_reg);
    assign rem_fix = v_reg - prod_reg[31:0];
    assign q_fix   = {1'b0, q_reg} + {32'd0, (rem_fix >= {23'd0, den})};
    assign t_new   = (q_fix >= {2'b00, ONE_Q30}) ? 31'd0 : (ONE_Q30 - q_fix[30:0]);

    // divider step
    assign cpm_eff = (cpm_reg == 16'd0) ? 16'd1 : cpm_reg;
    assign rem_sh  = {rem_reg, dq_reg[47]};
    assign div_ge  = (rem_sh >= {1'b0, cpm_eff});

    assign sx   = prod_reg[60:30];
    assign qsum = {1'b0, prod_reg[54:0], 24'd0} + {25'd0, pl_reg};
    assign qmag = qsum[78:30];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_take) state_next = ST_ANG;
            ST_ANG:  state_next = ST_SQR;
            ST_SQR:  state_next = ST_X2;
            ST_X2:   state_next = ST_MT;
            ST_MT:   state_next = ST_MM;
            ST_MM:   state_next = ST_MD;
            ST_MD:   state_next = ST_FIX;
            ST_FIX:
            begin
                if (k_reg != 3'd0 || phase_reg == PH_SIN)
                    state_next = ST_MT;
                else if (phase_reg == PH_SINC)
                    state_next = ST_PMUL;
                else
                    state_next = ST_SXM;
            end
            ST_PMUL: state_next = ST_PDIV;
            ST_PDIV: state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == 6'(DIV_STEPS - 1)) state_next = ST_ANG;
            ST_SXM:  state_next = ST_TRIG;
            ST_TRIG: state_next = ST_XL;
            ST_XL:   state_next = ST_XH;
            ST_XH:   state_next = ST_XS;
            ST_XS:   state_next = ST_YL;
            ST_YL:   state_next = ST_YH;
            ST_YH:   state_next = ST_YS;
            ST_YS:   state_next = ST_DONE;
            ST_DONE: if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (state_reg)
            ST_ANG:
            begin
                mul_a = {16'd0, r_reg};
                mul_b = PI_Q30;
            end
            ST_SQR:
            begin
                mul_a = prod_reg[47:16];
                mul_b = prod_reg[47:16];
            end
            ST_MT:
            begin
                mul_a = x2_reg;
                mul_b = {1'b0, t_reg};
            end
            ST_MM:
            begin
                mul_a = prod_reg[61:30];
                mul_b = ser_recip(is_cos, k_reg);
            end
            ST_MD:
            begin
                mul_a = prod_reg[63:32];
                mul_b = {23'd0, den};
            end
            ST_PMUL:
            begin
                mul_a = lmag_reg;
                mul_b = {1'b0, sinc_reg};
            end
            ST_SXM:
            begin
                mul_a = x_reg;
                mul_b = {1'b0, sinc_reg};
            end
            ST_XL:
            begin
                mul_a = {8'd0, dq_reg[23:0]};
                mul_b = {1'b0, c_reg};
            end
            ST_XH:
            begin
                mul_a = {8'd0, dq_reg[47:24]};
                mul_b = {1'b0, c_reg};
            end
            ST_YL:
            begin
                mul_a = {8'd0, dq_reg[23:0]};
                mul_b = {1'b0, s_reg};
            end
            ST_YH:
            begin
                mul_a = {8'd0, dq_reg[47:24]};
                mul_b = {1'b0, s_reg};
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_SINC;
            cpm_reg          <= CPM_RESET;
            last_count_reg   <= 32'd0;
            last_heading_reg <= 16'd0;
            pos_x_reg        <= 32'sd0;
            pos_y_reg        <= 32'sd0;
            k_reg            <= 3'd0;
            cnt_reg          <= 6'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                cpm_reg <= counts_per_meter;
            if (in_take)
            begin
                last_count_reg   <= encoder_count;
                last_heading_reg <= yaw_angle;
                phase_reg        <= PH_SINC;
            end
            if (state_reg == ST_X2)
                k_reg <= 3'(SER_TERMS - 1);
            if (state_reg == ST_FIX)
            begin
                if (k_reg != 3'd0)
                    k_reg <= k_reg - 3'd1;
                else if (phase_reg == PH_SIN)
                begin
                    k_reg     <= 3'(SER_TERMS - 1);
                    phase_reg <= PH_COS;
                end
            end
            if (state_reg == ST_PDIV)
                cnt_reg <= 6'd0;
            if (state_reg == ST_DIV)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_STEPS - 1))
                    phase_reg <= PH_SIN;
            end
            if (state_reg == ST_XS)
                pos_x_reg <= sat_add(pos_x_reg, qmag, lneg_reg ^ cneg_reg);
            if (state_reg == ST_YS)
                pos_y_reg <= sat_add(pos_y_reg, qmag, lneg_reg ^ sneg_reg);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            lneg_reg <= du[31];
            lmag_reg <= du[31] ? (32'd0 - du) : du;
            phi2_reg <= phi2;
            yaw_reg  <= yaw_angle;
            r_reg    <= dmag;
        end
        if (state_reg == ST_SQR)
            x_reg <= prod_reg[47:16];
        if (state_reg == ST_X2)
        begin
            x2_reg <= prod_reg[61:30];
            t_reg  <= ONE_Q30;
        end
        if (state_reg == ST_MM)
            v_reg <= prod_reg[61:30];
        if (state_reg == ST_MD)
            q_reg <= prod_reg[63:32];
        if (state_reg == ST_FIX)
        begin
            if (k_reg == 3'd0 && phase_reg == PH_SIN)
                t_reg <= ONE_Q30;
            else
                t_reg <= t_new;
            if (k_reg == 3'd0)
            begin
                if (phase_reg == PH_SINC || phase_reg == PH_SIN)
                    sinc_reg <= t_new;
            end
        end
        if (state_reg == ST_PDIV)
        begin
            dq_reg  <= prod_reg[61:14];
            rem_reg <= 16'd0;
        end
        if (state_reg == ST_DIV)
        begin
            dq_reg  <= {dq_reg[46:0], div_ge};
            rem_reg <= div_ge ? 16'(rem_sh - {1'b0, cpm_eff}) : rem_sh[15:0];
            if (cnt_reg == 6'(DIV_STEPS - 1))
                r_reg <= {1'b0, phi2_reg[14:0]};
        end
        if (state_reg == ST_TRIG)
        begin
            unique case (phi2_reg[16:15])
                2'd0:
                begin
                    c_reg <= t_reg; cneg_reg <= 1'b0;
                    s_reg <= sx;    sneg_reg <= 1'b0;
                end
                2'd1:
                begin
                    c_reg <= sx;    cneg_reg <= 1'b1;
                    s_reg <= t_reg; sneg_reg <= 1'b0;
                end
                2'd2:
                begin
                    c_reg <= t_reg; cneg_reg <= 1'b1;
                    s_reg <= sx;    sneg_reg <= 1'b1;
                end
                default:
                begin
                    c_reg <= sx;    cneg_reg <= 1'b0;
                    s_reg <= t_reg; sneg_reg <= 1'b1;
                end
            endcase
        end
        if (state_reg == ST_XH || state_reg == ST_YH)
            pl_reg <= prod_reg[54:0];
        if (out_load)
        begin
            out_x_reg <= pos_x_reg;
            out_y_reg <= pos_y_reg;
            out_h_reg <= yaw_reg;
        end
    end

endmodule

>>> design/ardo_checker.sv
// ----------------------------------------------------------------------------
// ardo_checker: port-level checks for the arc odometry block
// Watches the request channels of the top level over time.
// ----------------------------------------------------------------------------
module ardo_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] pose_x,
    input logic signed [31:0] pose_y,
    input logic signed [15:0] heading
);

    // one request in flight: no second take right after a take
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // a result never appears right after a take while no result is showing
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared too early");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pose_x)
            && $stable(pose_y) && $stable(heading))
        else $error("stalled result changed");

endmodule

bind arc_dead_reckoning_odometry ardo_checker u_ardo_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pose_x     (pose_x),
    .pose_y     (pose_y),
    .heading    (heading)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: arc odometry testbench
// Drives encoder/yaw requests through valid/ready with random gaps and output
// stalls, predicts each pose with a bit-exact fixed-point arc model (typed
// rows use hand-derived poses) and compares each returned pose field by field.
// Walks several counts_per_meter settings (zero, extremes) and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top
    import ardo_pkg::*;
;

    localparam int          N_RANDOM   = 500;
    localparam int          DRAIN_WAIT = 250;
    localparam int          LONG_HOLD  = 2000;
    localparam longint unsigned PI_FX  = 64'd3373259426;
    localparam longint unsigned ONE_FX = 64'd1 << 30;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] h;
    } pose_t;

    typedef struct {
        logic signed [31:0] enc;
        logic signed [15:0] yaw;
        bit                 typed;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] encoder_count;
    logic signed [15:0] yaw_angle;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] heading;
    logic               cfg_valid;
    logic               cfg_ready;
    logic        [15:0] counts_per_meter;

    pose_t              pending_poses[$];
    int                 errors;
    int                 n_checked;
    int                 n_sent;
    bit                 long_hold_req;
    bit                 quiet_sender;
    logic signed [31:0] sent_enc;
    logic signed [15:0] sent_yaw;

    // predictor state
    logic [15:0]        odo_cpm;
    logic [31:0]        odo_last_count;
    logic [15:0]        odo_last_yaw;
    longint             odo_x;
    longint             odo_y;

    arc_dead_reckoning_odometry uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .encoder_count    (encoder_count),
        .yaw_angle        (yaw_angle),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .pose_x           (pose_x),
        .pose_y           (pose_y),
        .heading          (heading),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .counts_per_meter (counts_per_meter)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("timeout at %0t", $time);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic longint unsigned taylor(longint unsigned x2, bit is_cos);
        longint unsigned sin_d[8];
        longint unsigned cos_d[8];
        longint unsigned t;
        longint unsigned sub;
        sin_d = '{6, 20, 42, 72, 110, 156, 210, 272};
        cos_d = '{2, 12, 30, 56, 90, 132, 182, 240};
        t = ONE_FX;
        for (int i = 7; i >= 0; i--)
        begin
            sub = ((x2 * t) >> 30) / (is_cos ? cos_d[i] : sin_d[i]);
            t = (sub >= ONE_FX) ? 64'd0 : ONE_FX - sub;
        end
        return t;
    endfunction

    function automatic longint unsigned rad_fx(longint unsigned r);
        return (r * PI_FX) >> 16;
    endfunction

    function automatic longint unsigned mul_fx(longint unsigned a, longint unsigned b);
        longint unsigned p;
        p = (a >> 20) * b;
        return (p >> 10) + ((((p & 64'd1023) << 20) + (a & 64'hFFFFF) * b) >> 30);
    endfunction

    function automatic longint clamp_add(longint acc, longint unsigned mag, bit neg);
        longint v;
        v = neg ? acc - longint'(mag) : acc + longint'(mag);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v;
    endfunction

    function automatic pose_t advance_odometry(logic [31:0] enc, logic [15:0] yaw);
        logic [31:0]     du;
        bit              lneg;
        longint unsigned lmag;
        logic [15:0]     dd;
        bit              dneg;
        longint unsigned dmag;
        logic [16:0]     phi;
        longint unsigned cpm;
        longint unsigned x;
        longint unsigned chord;
        longint unsigned sx;
        longint unsigned cx;
        longint unsigned c;
        longint unsigned s;
        bit              cneg;
        bit              sneg;
        pose_t           p;
        du   = enc - odo_last_count;
        lneg = du[31];
        lmag = lneg ? (64'h1_0000_0000 - du) : du;
        dd   = yaw - odo_last_yaw;
        dneg = dd[15];
        dmag = dneg ? 65536 - dd : dd;
        phi  = 17'({odo_last_yaw, 1'b0}) + dd + (dneg ? 17'h10000 : 17'h0);
        cpm  = (odo_cpm == 16'd0) ? 1 : odo_cpm;
        x     = rad_fx(dmag);
        chord = ((lmag * taylor((x * x) >> 30, 1'b0)) / cpm) >> 14;
        x  = rad_fx(phi[14:0]);
        sx = (x * taylor((x * x) >> 30, 1'b0)) >> 30;
        cx = taylor((x * x) >> 30, 1'b1);
        case (phi[16:15])
            2'd0: begin c = cx; cneg = 0; s = sx; sneg = 0; end
            2'd1: begin c = sx; cneg = 1; s = cx; sneg = 0; end
            2'd2: begin c = cx; cneg = 1; s = sx; sneg = 1; end
            default: begin c = sx; cneg = 0; s = cx; sneg = 1; end
        endcase
        odo_x = clamp_add(odo_x, mul_fx(chord, c), lneg != cneg);
        odo_y = clamp_add(odo_y, mul_fx(chord, s), lneg != sneg);
        odo_last_count = enc;
        odo_last_yaw   = yaw;
        p.x = odo_x[31:0];
        p.y = odo_y[31:0];
        p.h = yaw;
        return p;
    endfunction

    // one request; typed rows queue the hand-derived pose instead
    task automatic send_request(logic signed [31:0] enc, logic signed [15:0] yaw,
                                bit typed, logic signed [31:0] tx, logic signed [31:0] ty);
        pose_t p;
        int    gap;
        encoder_count <= enc;
        yaw_angle     <= yaw;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        p = advance_odometry(enc, yaw);
        if (typed)
        begin
            p.x = tx;
            p.y = ty;
        end
        pending_poses.push_back(p);
        sent_enc = enc;
        sent_yaw = yaw;
        n_sent++;
        if (!quiet_sender && $urandom_range(0, 9) < 4)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_poses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_cpm(logic [15:0] v);
        wait_drained();
        counts_per_meter <= v;
        cfg_valid        <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        odo_cpm = v;
    endtask

    task automatic random_request();
        logic signed [31:0] enc;
        logic signed [15:0] yaw;
        int                 pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            enc = sent_enc + $signed($urandom_range(0, 8000)) - 4000;
        else if (pick < 8)
            enc = sent_enc + $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
        else
            enc = $urandom;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            yaw = sent_yaw + 16'($signed($urandom_range(0, 2000)) - 1000);
        else
            yaw = 16'($urandom);
        send_request(enc, yaw, 1'b0, 0, 0);
    endtask

    // output side: random stalls, quiet stretches, and one long hold-off
    initial
    begin
        int n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(50, 300)) @(posedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(0, 2) != 0);
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 4);
                repeat (n) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        pose_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_poses.size() == 0)
            begin
                $display("%0t: pose with no request pending: x=%0d y=%0d h=%0d",
                         $time, pose_x, pose_y, heading);
                errors++;
            end
            else
            begin
                e = pending_poses.pop_front();
                n_checked++;
                if (pose_x !== e.x)
                begin
                    $display("%0t: pose_x expected %0d actual %0d", $time, e.x, pose_x);
                    errors++;
                end
                if (pose_y !== e.y)
                begin
                    $display("%0t: pose_y expected %0d actual %0d", $time, e.y, pose_y);
                    errors++;
                end
                if (heading !== e.h)
                begin
                    $display("%0t: heading expected %0d actual %0d", $time, e.h, heading);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        dir_row_t rows[$];
        logic [15:0] cpm_set[$];
        errors = 0;
        n_checked = 0;
        n_sent = 0;
        long_hold_req = 1'b0;
        quiet_sender = 1'b0;
        sent_enc = 0;
        sent_yaw = 0;
        odo_cpm = CPM_RESET;
        odo_last_count = '0;
        odo_last_yaw = '0;
        odo_x = 0;
        odo_y = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        encoder_count = '0;
        yaw_angle = '0;
        cfg_valid = 1'b0;
        counts_per_meter = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state, one meter straight, turns, wraps, half turns, extremes
        rows = '{
            '{32'sd0, 16'sd0, 1'b1, 32'sd0, 32'sd0},
            '{32'sd1140, 16'sd0, 1'b1, 32'sd65536, 32'sd0},
            '{32'sd2280, 16'sd16384, 1'b0, 0, 0},
            '{32'sd1140, -16'sd16384, 1'b0, 0, 0},
            '{32'sd3000, 16'sd32767, 1'b0, 0, 0},
            '{32'sd4000, -16'sd32768, 1'b0, 0, 0},
            '{32'sd5000, 16'sd0, 1'b0, 0, 0},
            '{32'sd6000, -16'sd32768, 1'b0, 0, 0},
            '{32'sd7000, 16'sd1, 1'b0, 0, 0},
            '{32'sd7000, -16'sd1, 1'b0, 0, 0},
            '{32'sh7FFF_FFFF, 16'sd8192, 1'b0, 0, 0},
            '{-32'sh8000_0000, 16'sd8192, 1'b0, 0, 0},
            '{32'sh7FFF_FFFF, -16'sd8192, 1'b0, 0, 0},
            '{-32'sd1, 16'sd24576, 1'b0, 0, 0},
            '{32'sd0, -16'sd24576, 1'b0, 0, 0},
            '{32'sd100, 16'sd0, 1'b0, 0, 0}
        };
        foreach (rows[i])
            send_request(rows[i].enc, rows[i].yaw, rows[i].typed, rows[i].x, rows[i].y);

        // saturation with one count per meter, then zero (treated as one), then 65535
        write_cpm(16'd1);
        send_request(sent_enc + 32'sh4000_0000, sent_yaw, 1'b0, 0, 0);
        send_request(sent_enc + 32'sh7FFF_0000, sent_yaw, 1'b0, 0, 0);
        send_request(sent_enc - 32'sh7FFF_0000, sent_yaw + 16'sd16384, 1'b0, 0, 0);
        write_cpm(16'd0);
        send_request(sent_enc - 32'sh7FFF_0000, -16'sd32768, 1'b0, 0, 0);
        send_request(sent_enc - 32'sh7FFF_0000, 16'sd0, 1'b0, 0, 0);
        write_cpm(16'd65535);
        send_request(sent_enc + 32'sh0100_0000, 16'sd12345, 1'b0, 0, 0);

        // output held off while requests keep coming: block stalls its input
        long_hold_req = 1'b1;
        quiet_sender = 1'b1;
        repeat (6) random_request();
        quiet_sender = 1'b0;

        cpm_set = '{16'd1140, 16'd1, 16'd65535, 16'd0, 16'd1024, 16'd0};
        cpm_set[5] = 16'($urandom_range(2, 65534));
        for (int ph = 0; ph < cpm_set.size(); ph++)
        begin
            write_cpm(cpm_set[ph]);
            quiet_sender = (ph == 2);
            for (int k = 0; k < N_RANDOM / cpm_set.size(); k++)
                random_request();
        end

        wait_drained();
        $display("%0d requests sent, %0d poses checked over several counts_per_meter values",
                 n_sent, n_checked);
        $display("covered stalls, zero and extreme scales, wraps and saturation");
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
